// ----- hw/rtl/rbp_pkg.sv -----
// Shared types and codes for the reference-counted block pool.
`default_nettype none
package rbp_pkg;

	// Operation codes carried by a request word.
	typedef logic [1:0] func_t;
	localparam func_t FN_INIT    = 2'd0;
	localparam func_t FN_ACQUIRE = 2'd1;
	localparam func_t FN_RELEASE = 2'd2;
	localparam func_t FN_RETAIN  = 2'd3;

	// Status codes carried by a response word.
	typedef logic [2:0] status_t;
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_BADARG  = 3'd1;
	localparam status_t ST_RANGE   = 3'd2;
	localparam status_t ST_EMPTY   = 3'd3;
	localparam status_t ST_IGNORED = 3'd4;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_POOL_ID      = 3'd0;
	localparam cfg_idx_t CFG_REGION_START = 3'd1;
	localparam cfg_idx_t CFG_REGION_SIZE  = 3'd2;
	localparam cfg_idx_t CFG_BLOCK_SIZE   = 3'd3;
	localparam cfg_idx_t CFG_ALIGNMENT    = 3'd4;
	localparam cfg_idx_t CFG_SLOT_COUNT   = 3'd5;

	localparam logic [15:0] REF_MAX = 16'hFFFF;

endpackage
`default_nettype wire

// ----- hw/rtl/rbp_if.sv -----
// Valid/ready channel interfaces for requests, responses and configuration writes.
`default_nettype none
interface rbp_req_if;
	import rbp_pkg::*;
	logic        valid;
	logic        ready;
	func_t       func;
	logic [7:0]  handle_pool;
	logic [15:0] handle_slot;
	modport source (output valid, func, handle_pool, handle_slot, input ready);
	modport sink (input valid, func, handle_pool, handle_slot, output ready);
endinterface

interface rbp_rsp_if;
	import rbp_pkg::*;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [31:0] block_address;
	logic [24:0] block_capacity;
	logic [11:0] block_slot;
	logic [7:0]  block_pool;
	logic [12:0] free_blocks;
	logic [12:0] low_water;
	logic [31:0] empty_hits;
	modport source (output valid, status, block_address, block_capacity, block_slot,
		block_pool, free_blocks, low_water, empty_hits, input ready);
	modport sink (input valid, status, block_address, block_capacity, block_slot,
		block_pool, free_blocks, low_water, empty_hits, output ready);
endinterface

interface rbp_cfg_if;
	import rbp_pkg::*;
	logic        valid;
	logic        ready;
	cfg_idx_t    index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/refcounted_block_pool.sv -----
// Top level of the reference-counted fixed block pool allocator.
// Hands out equal-sized blocks from a configured region through a LIFO free list and keeps a
// 16-bit reference count per slot. One request word is handled at a time. An acquire steps
// through a count write, a link read and multiply, and an address add before it loads the
// response register; release and retain read the count and update it before they load it,
// and a rejected request goes straight to loading it. Init runs a shared one-bit-per-cycle
// remainder unit over the 32 bits of the region start and the 24 bits of the block size,
// then a stride step, a multiply and a compare, then writes the link and count memories one slot a cycle.
// A response word that waits on the receiver holds the next request in its last step.
// Configuration writes are always taken and must only happen while the block is idle.
`default_nettype none
module refcounted_block_pool #(
	parameter int unsigned MAX_SLOTS = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rbp_req_if.sink   req,
	rbp_rsp_if.source rsp,
	rbp_cfg_if.sink   cfg
);
	import rbp_pkg::*;

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int UW = (26 + CW > 33) ? 26 + CW : 33;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DIV     = 4'd1;
	localparam logic [3:0] S_STRIDE  = 4'd2;
	localparam logic [3:0] S_MUL     = 4'd3;
	localparam logic [3:0] S_CMP     = 4'd4;
	localparam logic [3:0] S_FILL    = 4'd5;
	localparam logic [3:0] S_ACQ     = 4'd6;
	localparam logic [3:0] S_ACQ_MUL = 4'd7;
	localparam logic [3:0] S_ACQ_ADD = 4'd8;
	localparam logic [3:0] S_RR      = 4'd9;
	localparam logic [3:0] S_RR_UPD  = 4'd10;
	localparam logic [3:0] S_PUSH    = 4'd11;

	// Configuration registers.
	logic [7:0]  pool_id_q, alignment_q;
	logic [31:0] region_start_q, region_size_q;
	logic [23:0] block_size_q;
	logic [12:0] slot_count_q;

	// Pool state.
	logic [IW-1:0] free_head_q;
	logic [CW-1:0] free_total_q, low_mark_q, active_count_q;
	logic [31:0]   empty_counter_q, aligned_base_q;
	logic [24:0]   stride_q;
	logic [7:0]    active_pool_q;

	// Sequencer and work registers.
	logic [3:0]    state_q;
	logic [IW-1:0] idx_q;
	logic          is_release_q;
	logic [31:0]   div_q;
	logic [4:0]    bit_cnt_q;
	logic          div_phase_q;
	logic [7:0]    rem_q, mis_q, pad_q;
	logic [24:0]   str_q;
	logic [UW-1:0] prod_q;
	logic [31:0]   addr_prod_q;
	logic [31:0]   addr_q;
	status_t       st_q;
	logic          acq_ok_q;

	// Response register.
	logic          rsp_valid_q;
	status_t       rsp_status_q;
	logic [31:0]   rsp_addr_q;
	logic [24:0]   rsp_cap_q;
	logic [11:0]   rsp_slot_q;
	logic [7:0]    rsp_pool_q;
	logic [12:0]   rsp_free_q;
	logic [12:0]   rsp_low_q;
	logic [31:0]   rsp_empty_q;

	// Memory ports.
	logic          link_we, cnt_we;
	logic [IW-1:0] link_wdata, link_rdata;
	logic [15:0]   cnt_wdata, cnt_rdata;

	// Derived values.
	logic [7:0]    al;
	logic [8:0]    rem_sh;
	logic [7:0]    rem_next;
	logic [CW-1:0] fill_next;
	logic          fill_last;
	logic          acq_empty;
	logic          handle_bad;
	logic [UW-1:0] used;
	logic [CW-1:0] free_dec;
	logic [15:0]   cnt_dec;
	logic          out_free;

	assign al = (alignment_q == 8'd0) ? 8'd1 : alignment_q;

	// Shared remainder unit: one dividend bit per cycle.
	assign rem_sh   = {rem_q, div_q[31]};
	assign rem_next = (rem_sh >= {1'b0, al}) ? 8'(rem_sh - {1'b0, al}) : rem_sh[7:0];

	assign fill_next = CW'(idx_q) + CW'(1);
	assign fill_last = (fill_next >= active_count_q);
	assign acq_empty = (free_total_q == '0) || (CW'(free_head_q) >= active_count_q);
	assign handle_bad = (req.handle_pool != active_pool_q) ||
		({1'b0, req.handle_slot} >= 17'(active_count_q));
	assign used = UW'(pad_q) + prod_q;
	assign free_dec = free_total_q - CW'(1);
	assign cnt_dec = cnt_rdata - 16'd1;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	// Memory write controls; every access uses the work index.
	always_comb begin
		link_we    = 1'b0;
		link_wdata = free_head_q;
		cnt_we     = 1'b0;
		cnt_wdata  = 16'd0;
		case (state_q)
			S_FILL: begin
				link_we    = 1'b1;
				link_wdata = fill_last ? '0 : IW'(fill_next);
				cnt_we     = 1'b1;
			end
			S_ACQ: begin
				cnt_we    = 1'b1;
				cnt_wdata = 16'd1;
			end
			S_RR_UPD: begin
				if (cnt_rdata != 16'd0) begin
					cnt_we    = 1'b1;
					cnt_wdata = is_release_q ? cnt_dec
						: ((cnt_rdata == REF_MAX) ? cnt_rdata : cnt_rdata + 16'd1);
					link_we   = is_release_q && (cnt_dec == 16'd0);
				end
			end
			default: begin
			end
		endcase
	end

	rbp_ram #(.WIDTH(IW), .DEPTH(MAX_SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (idx_q),
		.wdata (link_wdata),
		.raddr (idx_q),
		.rdata (link_rdata)
	);

	rbp_ram #(.WIDTH(16), .DEPTH(MAX_SLOTS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (idx_q),
		.wdata (cnt_wdata),
		.raddr (idx_q),
		.rdata (cnt_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_id_q      <= 8'd0;
			region_start_q <= 32'd0;
			region_size_q  <= 32'd0;
			block_size_q   <= 24'd0;
			alignment_q    <= 8'd1;
			slot_count_q   <= 13'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_POOL_ID:      pool_id_q      <= cfg.data[7:0];
				CFG_REGION_START: region_start_q <= cfg.data;
				CFG_REGION_SIZE:  region_size_q  <= cfg.data;
				CFG_BLOCK_SIZE:   block_size_q   <= cfg.data[23:0];
				CFG_ALIGNMENT:    alignment_q    <= cfg.data[7:0];
				CFG_SLOT_COUNT:   slot_count_q   <= cfg.data[12:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and pool state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			free_head_q     <= '0;
			free_total_q    <= '0;
			low_mark_q      <= '0;
			active_count_q  <= '0;
			empty_counter_q <= 32'd0;
			aligned_base_q  <= 32'd0;
			stride_q        <= 25'd0;
			active_pool_q   <= 8'd0;
			st_q            <= ST_OK;
			acq_ok_q        <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					acq_ok_q <= 1'b0;
					if (req.valid) begin
						case (req.func)
							FN_INIT: begin
								if (block_size_q == 24'd0 || slot_count_q == 13'd0) begin
									st_q    <= ST_BADARG;
									state_q <= S_PUSH;
								end else if (32'(slot_count_q) > 32'(MAX_SLOTS)) begin
									st_q    <= ST_RANGE;
									state_q <= S_PUSH;
								end else begin
									div_q       <= region_start_q;
									bit_cnt_q   <= 5'd31;
									div_phase_q <= 1'b0;
									rem_q       <= 8'd0;
									state_q     <= S_DIV;
								end
							end
							FN_ACQUIRE: begin
								if (acq_empty) begin
									empty_counter_q <= empty_counter_q + 32'd1;
									st_q            <= ST_EMPTY;
									state_q         <= S_PUSH;
								end else begin
									idx_q   <= free_head_q;
									state_q <= S_ACQ;
								end
							end
							default: begin
								is_release_q <= (req.func == FN_RELEASE);
								idx_q        <= IW'(req.handle_slot);
								if (handle_bad) begin
									st_q    <= ST_IGNORED;
									state_q <= S_PUSH;
								end else begin
									state_q <= S_RR;
								end
							end
						endcase
					end
				end
				// Remainder of region start, then of block size, by the alignment.
				S_DIV: begin
					rem_q     <= rem_next;
					div_q     <= {div_q[30:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - 5'd1;
					if (bit_cnt_q == 5'd0) begin
						if (!div_phase_q) begin
							mis_q       <= rem_next;
							rem_q       <= 8'd0;
							div_q       <= {block_size_q, 8'd0};
							bit_cnt_q   <= 5'd23;
							div_phase_q <= 1'b1;
						end else begin
							state_q <= S_STRIDE;
						end
					end
				end
				// Padding to the aligned base and block size rounded up to the alignment.
				S_STRIDE: begin
					pad_q   <= (mis_q == 8'd0) ? 8'd0 : al - mis_q;
					str_q   <= (rem_q == 8'd0) ? {1'b0, block_size_q}
						: {1'b0, block_size_q} + 25'(al) - 25'(rem_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= UW'(str_q * slot_count_q);
					state_q <= S_CMP;
				end
				// Fit check, then commit the new pool geometry.
				S_CMP: begin
					if (used > UW'(region_size_q)) begin
						st_q    <= ST_RANGE;
						state_q <= S_PUSH;
					end else begin
						aligned_base_q  <= region_start_q + 32'(pad_q);
						stride_q        <= str_q;
						active_count_q  <= CW'(slot_count_q);
						free_total_q    <= CW'(slot_count_q);
						low_mark_q      <= CW'(slot_count_q);
						active_pool_q   <= pool_id_q;
						empty_counter_q <= 32'd0;
						free_head_q     <= '0;
						idx_q           <= '0;
						state_q         <= S_FILL;
					end
				end
				// Link every slot free, one slot a cycle.
				S_FILL: begin
					idx_q <= IW'(fill_next);
					if (fill_last) begin
						st_q    <= ST_OK;
						state_q <= S_PUSH;
					end
				end
				S_ACQ: begin
					free_total_q <= free_dec;
					if (free_dec < low_mark_q) begin
						low_mark_q <= free_dec;
					end
					state_q <= S_ACQ_MUL;
				end
				S_ACQ_MUL: begin
					free_head_q <= link_rdata;
					addr_prod_q <= 32'(idx_q * stride_q);
					state_q     <= S_ACQ_ADD;
				end
				S_ACQ_ADD: begin
					addr_q   <= aligned_base_q + addr_prod_q;
					acq_ok_q <= 1'b1;
					st_q     <= ST_OK;
					state_q  <= S_PUSH;
				end
				S_RR: begin
					state_q <= S_RR_UPD;
				end
				// Count update; a release that reaches zero pushes the slot back.
				S_RR_UPD: begin
					if (cnt_rdata == 16'd0) begin
						st_q <= ST_IGNORED;
					end else begin
						st_q <= ST_OK;
						if (is_release_q && cnt_dec == 16'd0) begin
							free_head_q  <= idx_q;
							free_total_q <= free_total_q + CW'(1);
						end
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response payload, loaded as the word is handed over; counters are captured so that
	// a waiting word stays stable while the next request runs.
	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && out_free) begin
			rsp_status_q <= st_q;
			rsp_addr_q   <= acq_ok_q ? addr_q : 32'd0;
			rsp_cap_q    <= acq_ok_q ? stride_q : 25'd0;
			rsp_slot_q   <= acq_ok_q ? 12'(idx_q) : 12'd0;
			rsp_pool_q   <= acq_ok_q ? active_pool_q : 8'd0;
			rsp_free_q   <= 13'(free_total_q);
			rsp_low_q    <= 13'(low_mark_q);
			rsp_empty_q  <= empty_counter_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.block_address  = rsp_addr_q;
	assign rsp.block_capacity = rsp_cap_q;
	assign rsp.block_slot     = rsp_slot_q;
	assign rsp.block_pool     = rsp_pool_q;
	assign rsp.free_blocks    = rsp_free_q;
	assign rsp.low_water      = rsp_low_q;
	assign rsp.empty_hits     = rsp_empty_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rbp_checker.sv -----
// Port-level assertions for the block pool and the bind that attaches them.
`default_nettype none
module rbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic [2:0]  rsp_status,
	input wire logic [31:0] rsp_block_address,
	input wire logic [24:0] rsp_block_capacity,
	input wire logic [12:0] rsp_free_blocks,
	input wire logic [12:0] rsp_low_water
);
	import rbp_pkg::*;

	// The block is busy with a request word for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// A request that does not succeed reports no block address or capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |->
		rsp_block_address == 32'd0 && rsp_block_capacity == 25'd0)
		else $error("block reported on a failed request");

	// The low-water mark never exceeds the free count.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_low_water <= rsp_free_blocks)
		else $error("low-water mark above free count");

	// An empty answer means no block was free.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_free_blocks == 13'd0)
		else $error("pool reported empty with free blocks");

endmodule

bind refcounted_block_pool rbp_checker u_rbp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_status         (rsp.status),
	.rsp_block_address  (rsp.block_address),
	.rsp_block_capacity (rsp.block_capacity),
	.rsp_free_blocks    (rsp.free_blocks),
	.rsp_low_water      (rsp.low_water)
);
`default_nettype wire
